@@ rtl/rosp_pkg.sv @@
// Shared types and constants for the recency-ordered slot picker.
package rosp_pkg;

	// Default number of slots in the bank.
	localparam int SLOT_COUNT_DEF = 16;

	// Command codes carried by a request transaction.
	typedef enum logic [2:0] {
		CMD_SAVE_PICKED = 3'd0,
		CMD_SAVE_SLOT   = 3'd1,
		CMD_SELECT      = 3'd2,
		CMD_SEL_RECENT  = 3'd3,
		CMD_SEL_OLD     = 3'd4,
		CMD_SEL_RANDOM  = 3'd5,
		CMD_CLEAR_SLOT  = 3'd6,
		CMD_CLEAR_ALL   = 3'd7
	} cmd_t;

	// Request payload.
	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] centre;
		logic [15:0] width;
		logic [3:0]  slot;
		logic [15:0] rand_spread;
		logic [15:0] rand_bias;
	} req_t;

	// Result payload.
	typedef struct packed {
		logic [3:0] result_slot;
		logic       ok;
		logic [4:0] entries;
	} rsp_t;

	// Stage commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul;
		logic scale;
		logic bias;
		logic apply;
	} dp_ctrl_t;

endpackage

@@ rtl/recency_ordered_slot_picker.sv @@
// Each transaction passes through three serial multiply stages (offset products,
// scaling by the top position, bias lerp) and then the list update, after which the
// result strobe rises. A new transaction can enter during the previous one's update.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears the occupancy map, the list length and the controller; the list
// contents stay undefined until written and need no clearing pass.
module recency_ordered_slot_picker import rosp_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int MW = $clog2(SLOT_COUNT + 1);

	dp_ctrl_t      ctl;
	req_t          req_q;
	logic [MW-1:0] len;
	logic [MW-1:0] pos;

	// Stage sequencing.
	rosp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Position arithmetic.
	rosp_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk   (clk),
		.ctl   (ctl),
		.req   (req),
		.len   (len),
		.req_q (req_q),
		.pos   (pos)
	);

	// Slot bookkeeping and result register.
	rosp_list #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req_q),
		.pos    (pos),
		.len    (len),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

@@ rtl/rosp_ctrl.sv @@
// Controller state machine that sequences the picker's datapath stages.
module rosp_ctrl import rosp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output dp_ctrl_t ctl
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_SCALE = 5'b00100,
		ST_BIAS  = 5'b01000,
		ST_APPLY = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// A new transaction may enter while the previous one finishes its update cycle.
	assign busy   = !((state_q == ST_IDLE) || (state_q == ST_APPLY));
	assign accept = start && !busy;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  state_d = accept ? ST_MUL : ST_IDLE;
			ST_MUL:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_BIAS;
			ST_BIAS:  state_d = ST_APPLY;
			ST_APPLY: state_d = accept ? ST_MUL : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stage commands to the datapath.
	always_comb begin
		ctl.load  = accept;
		ctl.mul   = (state_q == ST_MUL);
		ctl.scale = (state_q == ST_SCALE);
		ctl.bias  = (state_q == ST_BIAS);
		ctl.apply = (state_q == ST_APPLY);
	end

	// The update state is always reached through the full multiply, scale and bias sequence.
	a_apply_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |-> ($past(state_q, 3) == ST_MUL))
		else $error("update cycle reached without the full multiply sequence");

endmodule

@@ rtl/rosp_dp.sv @@
// Position arithmetic datapath: request capture and the staged multiply chain.
module rosp_dp import rosp_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                               clk,
	input  dp_ctrl_t                           ctl,
	input  req_t                               req,
	input  logic [$clog2(SLOT_COUNT+1)-1:0]    len,
	output req_t                               req_q,
	output logic [$clog2(SLOT_COUNT+1)-1:0]    pos
);

	localparam int MW     = $clog2(SLOT_COUNT + 1);
	localparam int SUM_W  = 35 + MW;
	localparam int PROD_W = SUM_W + 17;
	localparam logic [MW-1:0] FULL_LEN = MW'(SLOT_COUNT);
	localparam logic signed [SUM_W-1:0] HALF_C = {{(SUM_W-32){1'b0}}, 32'h8000_0000};

	// Stage registers.
	logic [MW-1:0]              m_q;
	logic [MW-1:0]              rpos_q;
	logic [15+MW:0]             p1_q;
	logic signed [33:0]         p2_q;
	logic [15:0]                bias_q;
	logic signed [SUM_W-1:0]    s_q;
	logic signed [PROD_W-1:0]   prod_q;

	// First stage signals.
	logic [MW-1:0]              m_c;
	logic signed [16:0]         d_c;
	logic signed [33:0]         p2_c;
	logic [15+MW:0]             p1_c;
	logic [31:0]                bb_c;
	logic [31:0]                bsq_c;
	logic [15+MW:0]             rp_c;

	// Later stage signals.
	logic signed [SUM_W-1:0]    sm_c;
	logic signed [SUM_W-1:0]    s_c;
	logic signed [SUM_W-1:0]    t_c;
	logic signed [SUM_W-1:0]    diff_c;
	logic signed [PROD_W-1:0]   prod_c;
	logic                       mode_on;
	logic signed [PROD_W-1:0]   psh_c;
	logic signed [SUM_W-1:0]    sf_c;
	logic signed [SUM_W-1:0]    v_c;
	logic [SUM_W-33:0]          idx_c;
	logic [MW-1:0]              pick_c;

	// Highest usable position, offset products, bias square and random position.
	always_comb begin
		if ((req_q.cmd == CMD_SAVE_PICKED) && (len < FULL_LEN)) begin
			m_c = len;
		end else if (len != '0) begin
			m_c = len - 1'b1;
		end else begin
			m_c = '0;
		end
		d_c   = $signed({1'b0, req_q.rand_spread}) - 17'sd32768;
		p2_c  = 34'(d_c) * 34'($signed({1'b0, req_q.width}));
		p1_c  = (16+MW)'(req_q.centre) * (16+MW)'(m_c);
		bb_c  = 32'(req_q.rand_bias) * 32'(req_q.rand_bias);
		bsq_c = bb_c + 32'd32768;
		rp_c  = (16+MW)'(req_q.rand_spread) * (16+MW)'(len);
	end

	// Scaled target sum in units of 2^-32.
	always_comb begin
		sm_c = SUM_W'(p2_q) * SUM_W'($signed({1'b0, m_q}));
		s_c  = $signed({3'b000, p1_q, 16'h0000}) + sm_c;
	end

	// Pull toward the newest or the oldest end by half the bias.
	always_comb begin
		mode_on = (req_q.cmd == CMD_SEL_RECENT) || (req_q.cmd == CMD_SEL_OLD);
		if (req_q.cmd == CMD_SEL_RECENT) begin
			t_c = $signed({3'b000, m_q, 32'h0000_0000});
		end else begin
			t_c = '0;
		end
		diff_c = t_c - s_q;
		prod_c = PROD_W'(diff_c) * PROD_W'($signed({1'b0, bias_q}));
	end

	// Round half up, clamp to the usable range and pick the position.
	always_comb begin
		psh_c = prod_q >>> 17;
		sf_c  = s_q + $signed(psh_c[SUM_W-1:0]);
		v_c   = sf_c + HALF_C;
		idx_c = v_c[SUM_W-1:32];
		if (v_c[SUM_W-1]) begin
			pick_c = '0;
		end else if (idx_c > {3'b000, m_q}) begin
			pick_c = m_q;
		end else begin
			pick_c = idx_c[MW-1:0];
		end
		pos = (req_q.cmd == CMD_SEL_RANDOM) ? rpos_q : pick_c;
	end

	// Request capture and stage registers.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		if (ctl.mul) begin
			m_q    <= m_c;
			p1_q   <= p1_c;
			p2_q   <= p2_c;
			bias_q <= bsq_c[31:16];
			rpos_q <= rp_c[15+MW:16];
		end
		if (ctl.scale) begin
			s_q <= s_c;
		end
		if (ctl.bias) begin
			prod_q <= mode_on ? prod_c : '0;
		end
	end

endmodule

@@ rtl/rosp_list.sv @@
// Occupancy map, recency-ordered slot list and the result register.
module rosp_list import rosp_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dp_ctrl_t                        ctl,
	input  req_t                            req,
	input  logic [$clog2(SLOT_COUNT+1)-1:0] pos,
	output logic [$clog2(SLOT_COUNT+1)-1:0] len,
	output logic                            done,
	output rsp_t                            rsp
);

	localparam int MW = $clog2(SLOT_COUNT + 1);
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [MW-1:0] FULL_LEN = MW'(SLOT_COUNT);

	// State.
	logic [SLOT_COUNT-1:0] map_q;
	logic [MW-1:0]         len_q;
	logic [SW-1:0]         list_q [SLOT_COUNT];
	logic                  done_q;
	rsp_t                  rsp_q;

	// Decode and update signals.
	logic                  has_free;
	logic                  slot_ok;
	logic [SW-1:0]         slot_idx;
	logic [SW-1:0]         lf;
	logic [SW-1:0]         sel_entry;
	logic                  do_store;
	logic                  do_remove;
	logic                  clr_all;
	logic                  ok_c;
	logic [SW-1:0]         res_c;
	logic [SW-1:0]         tgt;
	logic [SLOT_COUNT-1:0] hit;
	logic                  present;
	logic [SW-1:0]         kidx;
	logic [SW-1:0]         nxt [SLOT_COUNT];
	logic [MW-1:0]         rem_len;
	logic [MW-1:0]         len_d;
	logic [SLOT_COUNT-1:0] tbit;
	logic [SLOT_COUNT-1:0] map_d;

	assign len       = len_q;
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign has_free  = len_q < FULL_LEN;
	assign slot_ok   = int'(req.slot) < SLOT_COUNT;
	assign slot_idx  = SW'(req.slot);
	assign sel_entry = list_q[pos[SW-1:0]];

	// Lowest free slot.
	always_comb begin
		lf = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!map_q[i]) begin
				lf = SW'(i);
			end
		end
	end

	// Command decode.
	always_comb begin
		do_store  = 1'b0;
		do_remove = 1'b0;
		clr_all   = 1'b0;
		ok_c      = 1'b0;
		res_c     = '0;
		tgt       = slot_idx;
		unique case (req.cmd)
			CMD_SAVE_PICKED: begin
				do_store = 1'b1;
				ok_c     = 1'b1;
				tgt      = (has_free && (pos == len_q)) ? lf : sel_entry;
				res_c    = tgt;
			end
			CMD_SAVE_SLOT: begin
				do_store = slot_ok;
				ok_c     = slot_ok;
				res_c    = slot_idx;
			end
			CMD_SELECT, CMD_SEL_RECENT, CMD_SEL_OLD, CMD_SEL_RANDOM: begin
				ok_c  = (len_q != '0);
				res_c = sel_entry;
			end
			CMD_CLEAR_SLOT: begin
				do_remove = slot_ok;
			end
			CMD_CLEAR_ALL: begin
				clr_all = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Find the target in the list.
	always_comb begin
		hit  = '0;
		kidx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			hit[i] = (i < int'(len_q)) && (list_q[i] == tgt);
			kidx   = kidx | (hit[i] ? SW'(i) : '0);
		end
		present = |hit;
		rem_len = len_q - MW'(present);
	end

	// Close the gap left by the target and append it at the newest end on a save.
	always_comb begin
		for (int i = 0; i < SLOT_COUNT - 1; i++) begin
			nxt[i] = (present && (i >= int'(kidx))) ? list_q[i+1] : list_q[i];
		end
		nxt[SLOT_COUNT-1] = list_q[SLOT_COUNT-1];
		if (do_store) begin
			nxt[rem_len[SW-1:0]] = tgt;
		end
	end

	// Next length and occupancy.
	always_comb begin
		tbit = {{(SLOT_COUNT-1){1'b0}}, 1'b1} << tgt;
		if (clr_all) begin
			len_d = '0;
			map_d = '0;
		end else if (do_store) begin
			len_d = rem_len + 1'b1;
			map_d = map_q | tbit;
		end else if (do_remove) begin
			len_d = rem_len;
			map_d = map_q & ~tbit;
		end else begin
			len_d = len_q;
			map_d = map_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q  <= '0;
			len_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.apply;
			if (ctl.apply) begin
				map_q <= map_d;
				len_q <= len_d;
			end
		end
	end

	// List contents and result payload.
	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			if (do_store || do_remove) begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					list_q[i] <= nxt[i];
				end
			end
			rsp_q.result_slot <= ok_c ? 4'(res_c) : 4'd0;
			rsp_q.ok          <= ok_c;
			rsp_q.entries     <= 5'(len_d);
		end
	end

	// The number of occupied slots always equals the list length.
	a_map_len: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(map_q) == int'(len_q))
		else $error("occupancy count and list length disagree");

	// The list never grows past the bank size.
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= FULL_LEN)
		else $error("list length exceeds slot count");

	// A result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

endmodule

@@ test/rosp_checker.sv @@
// Checker for the slot picker: predicts each transaction's result and compares it.
module rosp_checker import rosp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   mismatch_count,
	output int   awaiting_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BANK_SIZE = SLOT_COUNT_DEF;

	// Mirror of the bank: occupancy bits and the save order, oldest first.
	logic [BANK_SIZE-1:0] bank_occ;
	logic [3:0]           age_list [BANK_SIZE];
	int                   age_len;

	// Results predicted but not yet seen on the result port.
	rsp_t pending_rsp [$];
	rsp_t want;

	initial begin
		bank_occ = '0;
		age_len = 0;
		mismatch_count = 0;
		awaiting_count = 0;
		for (int i = 0; i < BANK_SIZE; i++) begin
			age_list[i] = '0;
		end
	end

	// List position from a centre and jittered spread, optionally pulled toward
	// one end. mode is 0 for plain, 1 toward recent, -1 toward old.
	function automatic int calc_position(logic [15:0] centre, logic [15:0] spread,
			logic [15:0] r, logic [15:0] b, int mode, int top_pos);
		longint c;
		longint w;
		longint rr;
		longint bb;
		longint s;
		longint t;
		longint bias;
		longint v;
		longint idx;
		c = centre;
		w = spread;
		rr = r;
		bb = b;
		if (top_pos == 0) begin
			return 0;
		end
		s = c * top_pos * 65536 + (rr - 32768) * w * top_pos;
		if (mode != 0) begin
			bias = (bb * bb + 32768) >>> 16;
			t = (mode > 0) ? (longint'(top_pos) <<< 32) : 64'sd0;
			// Arithmetic shift of a signed value rounds toward minus infinity.
			s = s + (((t - s) * bias) >>> 17);
		end
		v = s + 64'sh8000_0000;
		if (v < 0) begin
			return 0;
		end
		idx = v >>> 32;
		return (idx > top_pos) ? top_pos : int'(idx);
	endfunction

	function automatic int lowest_open_slot();
		for (int i = 0; i < BANK_SIZE; i++) begin
			if (!bank_occ[i]) begin
				return i;
			end
		end
		return -1;
	endfunction

	// Remove a slot from the save order, keeping the rest in order.
	function automatic void drop_slot(logic [3:0] s);
		int j;
		j = 0;
		for (int i = 0; i < age_len; i++) begin
			if (age_list[i] != s) begin
				age_list[j] = age_list[i];
				j++;
			end
		end
		age_len = j;
	endfunction

	// Mark a slot occupied and move it to the newest end.
	function automatic void commit_slot(logic [3:0] s);
		bank_occ[s] = 1'b1;
		drop_slot(s);
		if (age_len < BANK_SIZE) begin
			age_list[age_len] = s;
			age_len++;
		end
	endfunction

	// Apply one transaction to the mirror and return the result it should give.
	function automatic rsp_t predict_response(req_t item);
		rsp_t out;
		int   n;
		int   top_pos;
		int   pos;
		int   chosen;
		int   mode;
		bit   has_free;
		out = '0;
		n = age_len;
		chosen = -1;
		case (item.cmd)
			CMD_SAVE_PICKED: begin
				has_free = (n < BANK_SIZE);
				top_pos = has_free ? n : ((n > 0) ? n - 1 : 0);
				pos = calc_position(item.centre, item.width, item.rand_spread, 16'd0, 0,
						top_pos);
				// Landing one past the list while a slot is free takes a fresh slot.
				if (has_free && pos == n) begin
					chosen = lowest_open_slot();
				end else if (n > 0) begin
					if (pos > n - 1) begin
						pos = n - 1;
					end
					chosen = age_list[pos];
				end else begin
					chosen = lowest_open_slot();
				end
				if (chosen >= 0) begin
					commit_slot(chosen[3:0]);
					out.result_slot = chosen[3:0];
					out.ok = 1'b1;
				end
			end
			CMD_SAVE_SLOT: begin
				commit_slot(item.slot);
				out.result_slot = item.slot;
				out.ok = 1'b1;
			end
			CMD_SELECT, CMD_SEL_RECENT, CMD_SEL_OLD, CMD_SEL_RANDOM: begin
				// An empty list answers with no slot.
				if (n > 0) begin
					if (item.cmd == CMD_SEL_RANDOM) begin
						pos = int'((longint'(item.rand_spread) * n) >>> 16);
					end else begin
						mode = (item.cmd == CMD_SELECT) ? 0 :
								((item.cmd == CMD_SEL_RECENT) ? 1 : -1);
						pos = calc_position(item.centre, item.width, item.rand_spread,
								item.rand_bias, mode, n - 1);
					end
					if (pos > n - 1) begin
						pos = n - 1;
					end
					out.result_slot = age_list[pos];
					out.ok = 1'b1;
				end
			end
			CMD_CLEAR_SLOT: begin
				bank_occ[item.slot] = 1'b0;
				drop_slot(item.slot);
			end
			default: begin
				bank_occ = '0;
				age_len = 0;
			end
		endcase
		out.entries = age_len[4:0];
		return out;
	endfunction

	// Check results first so that a result arriving with no expectation is caught,
	// then record the transaction accepted at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					$error("result transaction with no expectation waiting");
					mismatch_count++;
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.result_slot !== want.result_slot) begin
						$error("result_slot: expected %0d, actual %0d",
								want.result_slot, rsp.result_slot);
						mismatch_count++;
					end
					if (rsp.ok !== want.ok) begin
						$error("ok: expected %0d, actual %0d", want.ok, rsp.ok);
						mismatch_count++;
					end
					if (rsp.entries !== want.entries) begin
						$error("entries: expected %0d, actual %0d",
								want.entries, rsp.entries);
						mismatch_count++;
					end
				end
			end
			if (start && !busy) begin
				pending_rsp.insert(pending_rsp.size(), predict_response(req));
			end
			awaiting_count = pending_rsp.size();
		end
	end

endmodule

@@ test/recency_ordered_slot_picker_tb.sv @@
// Testbench top for the slot picker: clock, reset, stimulus and the verdict.
module recency_ordered_slot_picker_tb;
	import rosp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;
	int   mismatch_count;
	int   awaiting_count;
	int   gap_pct = 0;

	int   phase_gap [4] = '{0, 53, 12, 0};

	recency_ordered_slot_picker uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	rosp_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.mismatch_count(mismatch_count),
		.awaiting_count(awaiting_count)
	);

	// 12 ns clock.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hard limit on the run.
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic req_t make_req(cmd_t cmd, logic [15:0] centre, logic [15:0] spread,
			logic [3:0] slot, logic [15:0] r, logic [15:0] b);
		req_t item;
		item.cmd = cmd;
		item.centre = centre;
		item.width = spread;
		item.slot = slot;
		item.rand_spread = r;
		item.rand_bias = b;
		return item;
	endfunction

	// Fractions lean on the extremes now and then.
	function automatic logic [15:0] rand_frac();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	// Saves outweigh clears so the bank often runs full.
	function automatic req_t random_req();
		req_t item;
		int   sel;
		sel = $urandom_range(99);
		item = make_req(CMD_SAVE_PICKED, rand_frac(), rand_frac(),
				4'($urandom_range(15)), rand_frac(), rand_frac());
		if (sel < 30) begin
			item.cmd = CMD_SAVE_PICKED;
		end else if (sel < 55) begin
			item.cmd = CMD_SAVE_SLOT;
		end else if (sel < 62) begin
			item.cmd = CMD_SELECT;
		end else if (sel < 69) begin
			item.cmd = CMD_SEL_RECENT;
		end else if (sel < 76) begin
			item.cmd = CMD_SEL_OLD;
		end else if (sel < 83) begin
			item.cmd = CMD_SEL_RANDOM;
		end else if (sel < 98) begin
			item.cmd = CMD_CLEAR_SLOT;
		end else begin
			item.cmd = CMD_CLEAR_ALL;
		end
		return item;
	endfunction

	// Offer one transaction, with a random idle gap first, and hold it until taken.
	// start stays high afterwards so back-to-back transactions need no toggle.
	task automatic issue(input req_t item);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < gap_pct);
		end
		start <= 1'b1;
		req <= item;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: every command but the slot save on an empty bank, then saves and selects at the extremes.
		issue(make_req(CMD_SELECT,      16'h8000, 16'h0000, 4'd0,  16'h8000, 16'h0000));
		issue(make_req(CMD_SEL_RECENT,  16'h8000, 16'hFFFF, 4'd0,  16'hFFFF, 16'hFFFF));
		issue(make_req(CMD_SEL_OLD,     16'h0000, 16'hFFFF, 4'd0,  16'h0000, 16'hFFFF));
		issue(make_req(CMD_SEL_RANDOM,  16'h0000, 16'h0000, 4'd0,  16'hFFFF, 16'h0000));
		issue(make_req(CMD_CLEAR_ALL,   16'h0000, 16'h0000, 4'd0,  16'h0000, 16'h0000));
		issue(make_req(CMD_CLEAR_SLOT,  16'h0000, 16'h0000, 4'd5,  16'h0000, 16'h0000));
		issue(make_req(CMD_SAVE_PICKED, 16'h0000, 16'h0000, 4'd0,  16'h0000, 16'h0000));
		issue(make_req(CMD_SAVE_SLOT,   16'h0000, 16'h0000, 4'd15, 16'h0000, 16'h0000));
		issue(make_req(CMD_SAVE_SLOT,   16'h0000, 16'h0000, 4'd0,  16'h0000, 16'h0000));
		issue(make_req(CMD_SAVE_PICKED, 16'hFFFF, 16'h0000, 4'd0,  16'h0000, 16'h0000));
		issue(make_req(CMD_SAVE_PICKED, 16'h0000, 16'hFFFF, 4'd0,  16'h0000, 16'h0000));
		issue(make_req(CMD_SAVE_PICKED, 16'hFFFF, 16'hFFFF, 4'd0,  16'hFFFF, 16'h0000));
		issue(make_req(CMD_SAVE_PICKED, 16'h8000, 16'h0000, 4'd0,  16'h8000, 16'h0000));
		issue(make_req(CMD_SELECT,      16'hFFFF, 16'hFFFF, 4'd0,  16'hFFFF, 16'h0000));
		issue(make_req(CMD_SELECT,      16'h0000, 16'hFFFF, 4'd0,  16'h0000, 16'h0000));
		issue(make_req(CMD_SEL_RECENT,  16'h0000, 16'h0000, 4'd0,  16'h8000, 16'hFFFF));
		issue(make_req(CMD_SEL_OLD,     16'hFFFF, 16'h0000, 4'd0,  16'h8000, 16'hFFFF));
		issue(make_req(CMD_SEL_RECENT,  16'hFFFF, 16'hFFFF, 4'd0,  16'hFFFF, 16'h0000));
		issue(make_req(CMD_SEL_RANDOM,  16'h0000, 16'h0000, 4'd0,  16'hFFFF, 16'h0000));
		issue(make_req(CMD_SEL_RANDOM,  16'h0000, 16'h0000, 4'd0,  16'h0000, 16'h0000));
		issue(make_req(CMD_CLEAR_SLOT,  16'h0000, 16'h0000, 4'd15, 16'h0000, 16'h0000));
		issue(make_req(CMD_SELECT,      16'h8000, 16'h8000, 4'd0,  16'h8000, 16'h8000));
		issue(make_req(CMD_CLEAR_ALL,   16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF));

		// Random traffic in phases with different amounts of sender idling.
		foreach (phase_gap[p]) begin
			gap_pct = phase_gap[p];
			repeat (500) begin
				issue(random_req());
			end
		end
		start <= 1'b0;

		// Drain the outstanding results, then watch a little longer for strays.
		wait (awaiting_count == 0);
		repeat (12) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
